// File: src/lge_pkg.sv
package lge_pkg;
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int CNTW = $clog2(MAX_ROWS + 1);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_ADVANCE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] EDGE_DEAD = 2'd0;
	localparam logic [1:0] EDGE_MIRROR = 2'd1;
	localparam logic [1:0] EDGE_WRAP = 2'd2;

	localparam logic [3:0] REG_EDGE = 4'd0;
	localparam logic [3:0] REG_ROWS = 4'd4;
	localparam logic [3:0] REG_COLS = 4'd8;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] row;
		logic [5:0] col;
		logic alive;
	} item_t;

	typedef struct packed {
		logic cell_res;
		logic stable;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture item
		logic clr;       // clear one store row
		logic cell_rd;   // read the row of the captured item
		logic do_wr;     // single-cell write
		logic do_rd;     // single-cell read
		logic sw_rd;     // sweep: read store row
		logic sw_shift;  // sweep: shift the three-row window
		logic sw_tail;   // sweep: shift in the saved first row
		logic sw_first;  // sweep: save the first row
		logic sw_calc;   // sweep: compute and write one row
		logic adv_wb;    // load advance result
		logic [RW-1:0] row;
		logic [RW-1:0] crow;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CNTW-1:0] nr;
	} sts_t;

	// Next state of one row given rows above, self, below.
	function automatic logic [MAX_COLS-1:0] row_next(
		input logic [MAX_COLS-1:0] up, input logic [MAX_COLS-1:0] mid,
		input logic [MAX_COLS-1:0] dn, input logic [CW:0] nc, input logic [1:0] mode);
		logic [MAX_COLS-1:0] res;
		logic [3:0] n;
		logic [CW:0] cl, cr;
		logic lu, lm, ld, ru, rm, rd, lv, rv;
		res = mid;
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'd0;
			lv = 1'b1;
			rv = 1'b1;
			if (c == 0) begin
				if (mode == EDGE_MIRROR) cl = '0;
				else if (mode == EDGE_WRAP) cl = nc - (CW+1)'(1);
				else begin cl = '0; lv = 1'b0; end
			end else cl = (CW+1)'(c - 1);
			if ((CW+1)'(c + 1) >= nc) begin
				if (mode == EDGE_MIRROR) cr = nc - (CW+1)'(1);
				else if (mode == EDGE_WRAP) cr = '0;
				else begin cr = '0; rv = 1'b0; end
			end else cr = (CW+1)'(c + 1);
			lu = lv & up[cl[CW-1:0]]; lm = lv & mid[cl[CW-1:0]]; ld = lv & dn[cl[CW-1:0]];
			ru = rv & up[cr[CW-1:0]]; rm = rv & mid[cr[CW-1:0]]; rd = rv & dn[cr[CW-1:0]];
			n = 4'(lu) + 4'(lm) + 4'(ld) + 4'(ru) + 4'(rm) + 4'(rd) + 4'(up[c]) + 4'(dn[c]);
			if ((CW+1)'(c) < nc) begin
				if (n == 4'd3) res[c] = 1'b1;
				else if (n != 4'd2) res[c] = 1'b0;
			end
		end
		return res;
	endfunction
endpackage

// File: src/lge_if.sv
interface lge_in_if;
	logic valid;
	logic ready;
	lge_pkg::item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface lge_out_if;
	logic valid;
	logic ready;
	lge_pkg::res_t res;
	modport source(output valid, output res, input ready);
	modport sink(input valid, input res, output ready);
endinterface

// File: src/lge_ctrl.sv
module lge_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] op,
	output logic out_valid,
	input logic out_ready,
	input lge_pkg::sts_t sts,
	output lge_pkg::cmd_t cmd
);
	localparam int RW = lge_pkg::RW;
	localparam int NW = lge_pkg::CNTW;

	localparam logic [2:0] S_CLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_CELL = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_WB = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q;
	logic [1:0] op_q;
	logic [NW-1:0] step_q;
	logic acc;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid & in_ready;

	always_comb begin
		cmd = '0;
		cmd.load = acc;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				cmd.row = step_q[RW-1:0];
			end
			S_EXEC: cmd.cell_rd = op_q inside {lge_pkg::OP_WRITE, lge_pkg::OP_READ};
			S_CELL: begin
				cmd.do_wr = (op_q == lge_pkg::OP_WRITE);
				cmd.do_rd = (op_q == lge_pkg::OP_READ);
			end
			S_SWEEP: begin
				// fetch last row first, then rows 0..nr-1; compute trails fetch through rdata_q and the window
				cmd.sw_rd = (step_q <= sts.nr);
				cmd.row = (step_q == '0) ? RW'(sts.nr - NW'(1)) : RW'(step_q - NW'(1));
				cmd.sw_shift = (step_q != '0) && (step_q <= sts.nr + NW'(2));
				cmd.sw_tail = (step_q == sts.nr + NW'(2));
				cmd.sw_first = (step_q == NW'(2));
				cmd.sw_calc = (step_q >= NW'(4));
				cmd.crow = RW'(step_q - NW'(4));
			end
			S_WB: cmd.adv_wb = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			op_q <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (step_q == NW'(lge_pkg::MAX_ROWS - 1)) begin
						step_q <= '0;
						state_q <= S_IDLE;
					end else step_q <= step_q + NW'(1);
				end
				S_IDLE: if (acc) begin
					op_q <= op;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					step_q <= '0;
					if (op_q == lge_pkg::OP_ADVANCE) state_q <= S_SWEEP;
					else if (op_q inside {lge_pkg::OP_WRITE, lge_pkg::OP_READ})
						state_q <= S_CELL;
					else state_q <= S_OUT;
				end
				S_CELL: state_q <= S_OUT;
				S_SWEEP: begin
					// last row is computed at step nr+3
					if (step_q == sts.nr + NW'(3)) state_q <= S_WB;
					step_q <= step_q + NW'(1);
				end
				S_WB: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/lge_dp.sv
module lge_dp (
	input logic clk,
	input logic arst_n,
	input lge_pkg::item_t item,
	input lge_pkg::cmd_t cmd,
	input logic [1:0] edge_mode,
	input logic [6:0] row_count,
	input logic [6:0] col_count,
	output lge_pkg::sts_t sts,
	output lge_pkg::res_t res
);
	localparam int R = lge_pkg::MAX_ROWS;
	localparam int C = lge_pkg::MAX_COLS;
	localparam int RW = lge_pkg::RW;
	localparam int NW = lge_pkg::CNTW;
	localparam int NCW = lge_pkg::CW + 1;

	logic [C-1:0] mem [R];
	logic [C-1:0] rdata_q;
	logic [C-1:0] up_q, mid_q, dn_q, first_q;
	lge_pkg::item_t item_q;
	lge_pkg::res_t res_q;
	logic same_q;
	logic [NW-1:0] nr;
	logic [NCW-1:0] nc;
	logic re, we;
	logic [RW-1:0] raddr, waddr;
	logic [C-1:0] wdata, shift_in;
	logic [C-1:0] up, dn, nxt;

	always_comb begin
		if (row_count < 7'd2) nr = NW'(2);
		else if (row_count > 7'(R)) nr = NW'(R);
		else nr = NW'(row_count);
		if (col_count < 7'd2) nc = NCW'(2);
		else if (col_count > 7'(C)) nc = NCW'(C);
		else nc = NCW'(col_count);
	end
	assign sts.nr = nr;

	// Window holds rows crow-1, crow, crow+1 (wrapped); patch the board edges
	always_comb begin
		up = up_q;
		dn = dn_q;
		if (cmd.crow == '0) begin
			if (edge_mode == lge_pkg::EDGE_MIRROR) up = mid_q;
			else if (edge_mode != lge_pkg::EDGE_WRAP) up = '0;
		end
		if (NW'(cmd.crow) == nr - NW'(1)) begin
			if (edge_mode == lge_pkg::EDGE_MIRROR) dn = mid_q;
			else if (edge_mode != lge_pkg::EDGE_WRAP) dn = '0;
		end
		nxt = lge_pkg::row_next(up, mid_q, dn, nc, edge_mode);
	end

	always_comb begin
		re = cmd.cell_rd | cmd.sw_rd;
		raddr = cmd.cell_rd ? item_q.row : cmd.row;
		we = 1'b0;
		waddr = cmd.row;
		wdata = '0;
		if (cmd.clr) we = 1'b1;
		else if (cmd.do_wr) begin
			we = 1'b1;
			waddr = item_q.row;
			wdata = rdata_q;
			wdata[item_q.col] = item_q.alive;
		end else if (cmd.sw_calc) begin
			we = 1'b1;
			waddr = cmd.crow;
			wdata = nxt;
		end
		shift_in = cmd.sw_tail ? first_q : rdata_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
		if (cmd.sw_first) first_q <= rdata_q;
		if (cmd.sw_shift) begin
			up_q <= mid_q;
			mid_q <= dn_q;
			dn_q <= shift_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			same_q <= 1'b0;
		end else begin
			if (cmd.load) res_q <= '0;
			else if (cmd.do_wr) res_q <= '{cell_res: item_q.alive, stable: 1'b0};
			else if (cmd.do_rd) res_q <= '{cell_res: rdata_q[item_q.col], stable: 1'b0};
			else if (cmd.adv_wb) res_q <= '{cell_res: 1'b0, stable: same_q};
			if (cmd.load) same_q <= 1'b1;
			else if (cmd.sw_calc && nxt != mid_q) same_q <= 1'b0;
		end
	end

	assign res = res_q;
endmodule

// File: src/life_generation_engine_core.sv
// Game of Life engine (B3/S23) on a board of up to 64 by 64 cells, of which the
// saturated row_count by col_count is in use. Each input beat carries op, row,
// col and alive and produces one output beat; one beat is in flight at a time.
// After reset the board store is cleared one row per cycle, and in_ch.ready
// stays low until the clear is done. Write and read fetch the cell's row from
// the store and, for a write, put it back modified; the result is registered
// in the cell state and held until the receiver takes it. An advance streams
// the rows in use through a three-row window, reading one row and writing one
// new row per cycle; its result is loaded in the write-back state after the
// sweep and held while the receiver stalls.
// Edge mode, row and column counts are set through the APB port and must only
// be changed while no beat is in flight.
module life_generation_engine_core (
	input logic clk,
	input logic arst_n,
	lge_in_if.sink in_ch,
	lge_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	lge_pkg::cmd_t cmd;
	lge_pkg::sts_t sts;
	logic [1:0] edge_mode_q;
	logic [6:0] row_count_q, col_count_q;

	assign pready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_mode_q <= '0;
			row_count_q <= 7'd64;
			col_count_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				lge_pkg::REG_EDGE: edge_mode_q <= pwdata[1:0];
				lge_pkg::REG_ROWS: row_count_q <= pwdata[6:0];
				lge_pkg::REG_COLS: col_count_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			lge_pkg::REG_EDGE: prdata = {30'd0, edge_mode_q};
			lge_pkg::REG_ROWS: prdata = {25'd0, row_count_q};
			lge_pkg::REG_COLS: prdata = {25'd0, col_count_q};
			default: prdata = '0;
		endcase
	end

	// Sequencer: clear store, accept, execute, access a cell or sweep rows, hold result
	lge_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .op(in_ch.item.op),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	// Board store and next-generation row logic
	lge_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.item(in_ch.item), .cmd(cmd),
		.edge_mode(edge_mode_q), .row_count(row_count_q), .col_count(col_count_q),
		.sts(sts), .res(out_ch.res)
	);
endmodule

// File: tb/life_generation_engine_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the Game of Life engine.
// A directed table runs first, then phases of random beats under different
// edge modes, board sizes, idling and stalling. Every accepted input beat is
// run through the bench's own board model and the expected output beat is
// queued; every output beat is checked against the oldest queued one.
module life_generation_engine_core_tb;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int N_PHASES = 10;
	localparam int PHASE_BEATS = 45;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] EDGE_UNUSED = 2'd3;
	localparam logic [3:0] REG_NONE = 4'd12;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	lge_in_if in_ch ();
	lge_out_if out_ch ();

	life_generation_engine_core u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Board model and its settings, as the block should hold them.
	logic [lge_pkg::MAX_COLS-1:0] board [lge_pkg::MAX_ROWS];
	logic [1:0] edge_cfg;
	logic [6:0] rows_cfg, cols_cfg;

	lge_pkg::res_t expected_beats [$];
	int errors;
	int beats_checked;
	int advances_sent;
	int cycle_cnt;
	int idle_pct;   // sender idling, percent of cycles
	int stall_pct;  // receiver stalling, percent of cycles

	// A row of the directed table; has_exp marks rows whose answer is typed in.
	typedef struct {
		logic [1:0] op;
		logic [5:0] row;
		logic [5:0] col;
		logic alive;
		bit has_exp;
		logic exp_cell;
		logic exp_stable;
	} dir_row_t;

	dir_row_t dir_tab [22];

	typedef struct {
		logic [1:0] mode;
		logic [6:0] rows;
		logic [6:0] cols;
	} phase_cfg_t;

	phase_cfg_t phase_tab [N_PHASES];

	function automatic int clamp_size(input logic [6:0] v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	// Value of one neighbour position; r in -1..nr, c in -1..nc.
	function automatic logic neighbour_live(input int r, input int c, input int nr,
		input int nc, input logic [1:0] mode);
		if (mode == lge_pkg::EDGE_MIRROR) begin
			if (r < 0) r = 0;
			if (r >= nr) r = nr - 1;
			if (c < 0) c = 0;
			if (c >= nc) c = nc - 1;
		end else if (mode == lge_pkg::EDGE_WRAP) begin
			if (r < 0) r += nr;
			if (r >= nr) r -= nr;
			if (c < 0) c += nc;
			if (c >= nc) c -= nc;
		end else if (r < 0 || r >= nr || c < 0 || c >= nc) begin
			return 1'b0;
		end
		return board[r][c];
	endfunction

	// Step the board one generation; return 1 when nothing changed.
	function automatic logic step_generation();
		logic [lge_pkg::MAX_COLS-1:0] nxt [lge_pkg::MAX_ROWS];
		int nr, nc, n;
		logic same;
		nr = clamp_size(rows_cfg, lge_pkg::MAX_ROWS);
		nc = clamp_size(cols_cfg, lge_pkg::MAX_COLS);
		same = 1'b1;
		for (int r = 0; r < lge_pkg::MAX_ROWS; r++) nxt[r] = board[r];
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							n += neighbour_live(r + dr, c + dc, nr, nc, edge_cfg);
				if (n == 3) nxt[r][c] = 1'b1;
				else if (n != 2) nxt[r][c] = 1'b0;
			end
		end
		for (int r = 0; r < lge_pkg::MAX_ROWS; r++) begin
			if (nxt[r] != board[r]) same = 1'b0;
			board[r] = nxt[r];
		end
		return same;
	endfunction

	// Apply one accepted beat to the board model and return its answer.
	function automatic lge_pkg::res_t predict_beat(input lge_pkg::item_t it);
		lge_pkg::res_t r;
		r = '0;
		case (it.op)
			lge_pkg::OP_WRITE: begin
				board[it.row][it.col] = it.alive;
				r.cell_res = it.alive;
			end
			lge_pkg::OP_ADVANCE: r.stable = step_generation();
			lge_pkg::OP_READ: r.cell_res = board[it.row][it.col];
			default: ;
		endcase
		return r;
	endfunction

	// Drive one beat and hold it until the block takes it.
	task automatic send_beat(input lge_pkg::item_t it, input bit has_exp,
		input lge_pkg::res_t exp_res);
		lge_pkg::res_t pred;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.item <= it;
		do @(posedge clk); while (!in_ch.ready);
		pred = predict_beat(it);
		if (it.op == lge_pkg::OP_ADVANCE) advances_sent++;
		expected_beats.push_back(has_exp ? exp_res : pred);
	endtask

	// Drop valid and wait until every queued answer has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the access edge.
	task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == lge_pkg::REG_EDGE) edge_cfg = data[1:0];
		else if (addr == lge_pkg::REG_ROWS) rows_cfg = data[6:0];
		else if (addr == lge_pkg::REG_COLS) cols_cfg = data[6:0];
	endtask

	// Mostly beats aimed inside the board in use; some anywhere in the store.
	function automatic lge_pkg::item_t random_beat();
		lge_pkg::item_t it;
		int pick, nr, nc;
		nr = clamp_size(rows_cfg, lge_pkg::MAX_ROWS);
		nc = clamp_size(cols_cfg, lge_pkg::MAX_COLS);
		pick = $urandom_range(99);
		if (pick < 50) it.op = lge_pkg::OP_WRITE;
		else if (pick < 72) it.op = lge_pkg::OP_ADVANCE;
		else if (pick < 95) it.op = lge_pkg::OP_READ;
		else it.op = OP_UNUSED;
		if ($urandom_range(99) < 80) begin
			it.row = 6'($urandom_range(nr - 1));
			it.col = 6'($urandom_range(nc - 1));
		end else begin
			it.row = 6'($urandom_range(63));
			it.col = 6'($urandom_range(63));
		end
		it.alive = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic dir_row_t drow(input logic [1:0] op, input int r, input int c,
		input logic a, input bit k, input logic ec, input logic es);
		dir_row_t d;
		d.op = op; d.row = 6'(r); d.col = 6'(c); d.alive = a;
		d.has_exp = k; d.exp_cell = ec; d.exp_stable = es;
		return d;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check each output beat, then pick the next ready value.
	always @(posedge clk) begin
		lge_pkg::res_t want;
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, actual cell_res=%0b stable=%0b",
					$time, out_ch.res.cell_res, out_ch.res.stable);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				beats_checked++;
				if (out_ch.res.cell_res !== want.cell_res) begin
					$display("%0t: cell_res expected %0b actual %0b",
						$time, want.cell_res, out_ch.res.cell_res);
					errors++;
				end
				if (out_ch.res.stable !== want.stable) begin
					$display("%0t: stable expected %0b actual %0b",
						$time, want.stable, out_ch.res.stable);
					errors++;
				end
			end
		end
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats outstanding",
				cycle_cnt, expected_beats.size());
			$display("life_generation_engine_core: mismatch");
			$finish;
		end
	end

	initial begin
		lge_pkg::res_t exp_res;
		lge_pkg::item_t it;
		errors = 0;
		beats_checked = 0;
		advances_sent = 0;
		cycle_cnt = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.item = '0;
		out_ch.ready = 1'b1;
		edge_cfg = lge_pkg::EDGE_DEAD;
		rows_cfg = 7'd64;
		cols_cfg = 7'd64;
		for (int r = 0; r < lge_pkg::MAX_ROWS; r++) board[r] = '0;

		// Directed: reset state, store corners, unused op, a glider and a blinker.
		dir_tab[0] = drow(lge_pkg::OP_READ, 0, 0, 0, 1, 0, 0);
		dir_tab[1] = drow(lge_pkg::OP_ADVANCE, 0, 0, 0, 1, 0, 1);
		dir_tab[2] = drow(lge_pkg::OP_WRITE, 63, 63, 1, 1, 1, 0);
		dir_tab[3] = drow(lge_pkg::OP_READ, 63, 63, 1, 1, 1, 0);
		dir_tab[4] = drow(lge_pkg::OP_WRITE, 63, 63, 0, 1, 0, 0);
		dir_tab[5] = drow(lge_pkg::OP_WRITE, 0, 0, 1, 1, 1, 0);
		dir_tab[6] = drow(OP_UNUSED, 0, 0, 1, 1, 0, 0);
		dir_tab[7] = drow(lge_pkg::OP_READ, 0, 0, 0, 1, 1, 0);
		dir_tab[8] = drow(lge_pkg::OP_ADVANCE, 0, 0, 0, 1, 0, 0);
		dir_tab[9] = drow(lge_pkg::OP_WRITE, 1, 2, 1, 0, 0, 0);
		dir_tab[10] = drow(lge_pkg::OP_WRITE, 2, 3, 1, 0, 0, 0);
		dir_tab[11] = drow(lge_pkg::OP_WRITE, 3, 1, 1, 0, 0, 0);
		dir_tab[12] = drow(lge_pkg::OP_WRITE, 3, 2, 1, 0, 0, 0);
		dir_tab[13] = drow(lge_pkg::OP_WRITE, 3, 3, 1, 0, 0, 0);
		dir_tab[14] = drow(lge_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0);
		dir_tab[15] = drow(lge_pkg::OP_READ, 2, 1, 0, 0, 0, 0);
		dir_tab[16] = drow(lge_pkg::OP_WRITE, 62, 10, 1, 0, 0, 0);
		dir_tab[17] = drow(lge_pkg::OP_WRITE, 62, 11, 1, 0, 0, 0);
		dir_tab[18] = drow(lge_pkg::OP_WRITE, 62, 12, 1, 0, 0, 0);
		dir_tab[19] = drow(lge_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0);
		dir_tab[20] = drow(lge_pkg::OP_READ, 63, 11, 0, 0, 0, 0);
		dir_tab[21] = drow(lge_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0);

		phase_tab[0] = '{lge_pkg::EDGE_DEAD, 7'd64, 7'd64};
		phase_tab[1] = '{lge_pkg::EDGE_MIRROR, 7'd2, 7'd2};
		phase_tab[2] = '{lge_pkg::EDGE_WRAP, 7'd2, 7'd2};
		phase_tab[3] = '{lge_pkg::EDGE_WRAP, 7'd6, 7'd9};
		phase_tab[4] = '{lge_pkg::EDGE_MIRROR, 7'd64, 7'd64};
		phase_tab[5] = '{EDGE_UNUSED, 7'd0, 7'd127};
		phase_tab[6] = '{lge_pkg::EDGE_DEAD, 7'd1, 7'd5};
		phase_tab[7] = '{lge_pkg::EDGE_WRAP, 7'd64, 7'd64};
		phase_tab[8] = '{lge_pkg::EDGE_MIRROR, 7'd7, 7'd64};
		phase_tab[9] = '{lge_pkg::EDGE_DEAD, 7'd10, 7'd10};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) begin
			it.op = dir_tab[i].op;
			it.row = dir_tab[i].row;
			it.col = dir_tab[i].col;
			it.alive = dir_tab[i].alive;
			exp_res.cell_res = dir_tab[i].exp_cell;
			exp_res.stable = dir_tab[i].exp_stable;
			send_beat(it, dir_tab[i].has_exp, exp_res);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			// Settings change only while the block is idle.
			apb_write(lge_pkg::REG_EDGE, {30'd0, phase_tab[p].mode});
			apb_write(lge_pkg::REG_ROWS, {25'd0, phase_tab[p].rows});
			apb_write(lge_pkg::REG_COLS, {25'd0, phase_tab[p].cols});
			if (p == 5) apb_write(REG_NONE, 32'hFFFF_FFFF);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 59; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 59; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (int k = 0; k < PHASE_BEATS; k++) begin
				it = random_beat();
				send_beat(it, 1'b0, '0);
			end
		end

		drain();
		repeat (80) @(posedge clk);
		$display("covered %0d output beats, %0d advances, over %0d settings",
			beats_checked, advances_sent, N_PHASES + 1);
		$display("edge modes dead, mirror, wrap and unused; boards from 2x2 to 64x64");
		if (errors == 0) begin
			$display("life_generation_engine_core: match");
		end else begin
			$display("life_generation_engine_core: mismatch");
		end
		$finish;
	end
endmodule

// File: filelist.f
src/lge_pkg.sv
src/lge_if.sv
src/lge_ctrl.sv
src/lge_dp.sv
src/life_generation_engine_core.sv
tb/life_generation_engine_core_tb.sv
